>>> src/dring_pkg.sv
package dring_pkg;

   localparam int RING_SLOTS_DEF = 64;

   localparam int MODE_W   = 2;
   localparam int IDX_W    = 6;
   localparam int TAG_W    = 32;
   localparam int SIZE_W   = 16;
   localparam int LEN_W    = 16;
   localparam int ERR_W    = 8;
   localparam int STATUS_W = 2;

   // Slot status word: {done, error, length}
   localparam int STAT_W   = LEN_W + 2;
   localparam int DONE_BIT = LEN_W + 1;
   localparam int ERR_BIT  = LEN_W;

   localparam logic [SIZE_W-1:0] FRAME_LIMIT_RESET = 16'd1522;

   localparam logic RING_RX = 1'b0;
   localparam logic RING_TX = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD  = 2'd0,
      MODE_DONE = 2'd1,
      MODE_REAP = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED      = 2'd0,
      ST_FULL       = 2'd1,
      ST_BAD_SIZE   = 2'd2,
      ST_COMPLETION = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_MARK,
      S_READ,
      S_CHECK
   } fsm_type;

   typedef struct packed {
      logic tag_we;
      logic stat_we;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [IDX_W-1:0] tail;
      logic [IDX_W-1:0] slot;
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
      logic             err;
      logic             last;
   } result_type;

endpackage

>>> src/descriptor_ring_tracker_top.sv
// Descriptor ring tracker: a receive ring and a transmit ring of RING_SLOTS slots each.
//
// Channels
//   req_*  : one item per handshake (valid high, stall low). mode selects add buffer,
//            mark slot done (device write-back) or reap finished slots.
//   rsp_*  : result items. An add gives exactly one; a reap gives one per finished
//            slot walked from the head, the final one with rsp_last_flag set; done
//            items, empty reaps and the unused mode give nothing.
//   csr_*  : write of frame_limit (reset 1522); always ready, write only when idle.
//
// Timing
//   Items are handled one at a time; req_stall is high while one is in flight.
//   Add and done pass through S_ADD or S_MARK for the slot memories after accept;
//   a reap alternates S_READ, a read of the slot memories, with S_CHECK, which
//   inspects the registered read data, for each slot that it walks.
//   A completion is held back one slot so that its last mark is known.
//
// Reset clears both rings to empty and all done marks, through per-slot valid bits;
// no clearing pass is needed. While rsp_stall holds the output register full, the
// walk pauses with its read data held and no item is lost.
module descriptor_ring_tracker_top
   import dring_pkg::*;
#(
   parameter int RING_SLOTS = RING_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic                req_ring,
   input  logic [TAG_W-1:0]    req_buffer_tag,
   input  logic [SIZE_W-1:0]   req_buffer_size,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [LEN_W-1:0]    req_frame_length,
   input  logic [ERR_W-1:0]    req_error_bits,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_tail_index,
   output logic [IDX_W-1:0]    rsp_done_slot,
   output logic [TAG_W-1:0]    rsp_done_tag,
   output logic [LEN_W-1:0]    rsp_done_length,
   output logic                rsp_done_error,
   output logic                rsp_last_flag,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SIZE_W-1:0]   csr_frame_limit
);

   localparam int SLOT_W = $clog2(RING_SLOTS);
   localparam int ADDR_W = SLOT_W + 1;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [SIZE_W-1:0] frame_limit_ff;
   logic [DEPTH-1:0]  stat_known_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;

   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] mem_addr;
   logic [TAG_W-1:0]  tag_wdata, tag_rdata;
   logic [STAT_W-1:0] stat_wdata, stat_rdata;
   logic              out_free;
   result_type        res;

   // The output register frees up when empty or when its item leaves this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   dring_ctrl #(
      .RING_SLOTS (RING_SLOTS),
      .SLOT_W     (SLOT_W),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_ring         (req_ring),
      .req_buffer_tag   (req_buffer_tag),
      .req_buffer_size  (req_buffer_size),
      .req_slot_index   (req_slot_index),
      .req_frame_length (req_frame_length),
      .req_error_bits   (req_error_bits),
      .frame_limit      (frame_limit_ff),
      .mem_ctl          (mem_ctl),
      .mem_addr         (mem_addr),
      .tag_wdata        (tag_wdata),
      .stat_wdata       (stat_wdata),
      .tag_rdata        (tag_rdata),
      .stat_rdata       (stat_rdata),
      .stat_known       (stat_known_ff[mem_addr]),
      .out_free         (out_free),
      .result           (res)
   );

   // Buffer tags, written by adds.
   dring_ram #(
      .WIDTH (TAG_W),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock (clock),
      .we    (mem_ctl.tag_we),
      .re    (mem_ctl.rd_en),
      .addr  (mem_addr),
      .wdata (tag_wdata),
      .rdata (tag_rdata)
   );

   // Done mark, error flag and length; adds clear the mark, done items set it.
   dring_ram #(
      .WIDTH (STAT_W),
      .DEPTH (DEPTH)
   ) u_stat_ram (
      .clock (clock),
      .we    (mem_ctl.stat_we),
      .re    (mem_ctl.rd_en),
      .addr  (mem_addr),
      .wdata (stat_wdata),
      .rdata (stat_rdata)
   );

   // Per-slot valid bits: a slot never written reads as not done.
   always_ff @(posedge clock) begin
      if (reset) begin
         stat_known_ff <= '0;
      end else if (mem_ctl.stat_we) begin
         stat_known_ff[mem_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= FRAME_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         frame_limit_ff <= csr_frame_limit;
      end
   end

   // Output register: load a new item when free, drop the flag once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_tail_index  = rsp_ff.tail;
   assign rsp_done_slot   = rsp_ff.slot;
   assign rsp_done_tag    = rsp_ff.tag;
   assign rsp_done_length = rsp_ff.len;
   assign rsp_done_error  = rsp_ff.err;
   assign rsp_last_flag   = rsp_ff.last;

   // Never overwrite an item the receiver is still holding off.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !res.valid)
      else $error("result loaded over a stalled item");

   // Reads and writes of the slot memories never share a cycle.
   a_rd_wr_apart : assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |-> !mem_ctl.stat_we && !mem_ctl.tag_we)
      else $error("slot memory read and write in the same cycle");

   // An add writes the tag and clears the done mark together.
   a_add_pair : assert property (@(posedge clock) disable iff (reset)
      mem_ctl.tag_we |-> mem_ctl.stat_we && !stat_wdata[DONE_BIT])
      else $error("tag written without clearing the done mark");

   // A result is only produced while an item is in flight.
   a_res_busy : assert property (@(posedge clock) disable iff (reset)
      res.valid |-> req_stall)
      else $error("result produced while idle");

endmodule

>>> src/dring_ram.sv
module dring_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/dring_ctrl.sv
module dring_ctrl
   import dring_pkg::*;
#(
   parameter int RING_SLOTS = RING_SLOTS_DEF,
   parameter int SLOT_W     = $clog2(RING_SLOTS),
   parameter int ADDR_W     = SLOT_W + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic              req_ring,
   input  logic [TAG_W-1:0]  req_buffer_tag,
   input  logic [SIZE_W-1:0] req_buffer_size,
   input  logic [IDX_W-1:0]  req_slot_index,
   input  logic [LEN_W-1:0]  req_frame_length,
   input  logic [ERR_W-1:0]  req_error_bits,
   input  logic [SIZE_W-1:0] frame_limit,
   output mem_ctl_type       mem_ctl,
   output logic [ADDR_W-1:0] mem_addr,
   output logic [TAG_W-1:0]  tag_wdata,
   output logic [STAT_W-1:0] stat_wdata,
   input  logic [TAG_W-1:0]  tag_rdata,
   input  logic [STAT_W-1:0] stat_rdata,
   input  logic              stat_known,
   input  logic              out_free,
   output result_type        result
);

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_SLOTS - 1);
   localparam logic [IDX_W:0]    SLOT_LIM  = (IDX_W + 1)'(RING_SLOTS);

   fsm_type state_ff, state_in;

   // latched item
   logic              ring_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  sidx_ff;
   logic [LEN_W-1:0]  flen_ff;
   logic [ERR_W-1:0]  ebits_ff;

   // ring pointers
   logic              head_valid_ff [2];
   logic [SLOT_W-1:0] head_slot_ff  [2];
   logic [SLOT_W-1:0] next_free_ff  [2];

   // completion waiting for its last mark
   logic              pend_valid_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [TAG_W-1:0]  pend_tag_ff;
   logic [LEN_W-1:0]  pend_len_ff;
   logic              pend_err_ff;

   logic              accept;
   logic              cur_hv;
   logic [SLOT_W-1:0] cur_head, cur_free, head_next, free_next;
   logic              ring_full, size_bad, mark_ok, take;
   logic              do_add, do_capture, do_flush;

   assign accept    = req_valid && !req_stall;
   assign cur_hv    = head_valid_ff[ring_ff];
   assign cur_head  = head_slot_ff[ring_ff];
   assign cur_free  = next_free_ff[ring_ff];
   assign head_next = (cur_head == SLOT_LAST) ? '0 : cur_head + 1'b1;
   assign free_next = (cur_free == SLOT_LAST) ? '0 : cur_free + 1'b1;
   assign ring_full = cur_hv && (cur_free == cur_head || free_next == cur_head);
   assign size_bad  = (ring_ff == RING_TX) ? (size_ff > frame_limit)
                                           : (size_ff < frame_limit);
   assign mark_ok   = {1'b0, sidx_ff} < SLOT_LIM;
   assign take      = cur_hv && stat_known && stat_rdata[DONE_BIT];

   assign do_add     = (state_ff == S_ADD) && out_free && !ring_full && !size_bad;
   assign do_capture = (state_ff == S_CHECK) && take && (!pend_valid_ff || out_free);
   assign do_flush   = (state_ff == S_CHECK) && !take && pend_valid_ff && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (mode_type'(req_mode))
                  MODE_ADD:  state_in = S_ADD;
                  MODE_DONE: state_in = S_MARK;
                  MODE_REAP: state_in = S_READ;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_MARK:  state_in = S_IDLE;
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (take) begin
               if (!pend_valid_ff || out_free) begin
                  state_in = S_READ;
               end
            end else if (!pend_valid_ff || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = (state_ff != S_IDLE);
      mem_ctl    = '0;
      mem_addr   = {ring_ff, cur_head};
      tag_wdata  = tag_ff;
      stat_wdata = '0;
      result     = '0;
      unique case (state_ff)
         S_ADD: begin
            mem_addr = {ring_ff, cur_free};
            if (do_add) begin
               mem_ctl.tag_we  = 1'b1;
               mem_ctl.stat_we = 1'b1;
            end
            if (out_free) begin
               result.valid = 1'b1;
               result.last  = 1'b1;
               if (ring_full) begin
                  result.status = ST_FULL;
                  result.tail   = IDX_W'(cur_free);
               end else if (size_bad) begin
                  result.status = ST_BAD_SIZE;
                  result.tail   = IDX_W'(cur_free);
               end else begin
                  result.status = ST_ADDED;
                  result.tail   = IDX_W'(free_next);
               end
            end
         end
         S_MARK: begin
            mem_addr        = {ring_ff, SLOT_W'(sidx_ff)};
            mem_ctl.stat_we = mark_ok;
            stat_wdata      = {1'b1, ebits_ff != '0, flen_ff};
         end
         S_READ: begin
            mem_ctl.rd_en = 1'b1;
         end
         S_CHECK: begin
            if (pend_valid_ff && out_free) begin
               result.valid  = 1'b1;
               result.status = ST_COMPLETION;
               result.slot   = IDX_W'(pend_slot_ff);
               result.tag    = pend_tag_ff;
               result.len    = pend_len_ff;
               result.err    = pend_err_ff;
               result.last   = !take;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         for (int r = 0; r < 2; r++) begin
            head_valid_ff[r] <= 1'b0;
            head_slot_ff[r]  <= '0;
            next_free_ff[r]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (do_add) begin
            next_free_ff[ring_ff] <= free_next;
            if (!cur_hv) begin
               head_valid_ff[ring_ff] <= 1'b1;
               head_slot_ff[ring_ff]  <= cur_free;
            end
         end
         if (do_capture) begin
            pend_valid_ff         <= 1'b1;
            head_slot_ff[ring_ff] <= head_next;
            if (head_next == cur_free) begin
               head_valid_ff[ring_ff] <= 1'b0;
            end
         end else if (do_flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring_ff  <= req_ring;
         tag_ff   <= req_buffer_tag;
         size_ff  <= req_buffer_size;
         sidx_ff  <= req_slot_index;
         flen_ff  <= req_frame_length;
         ebits_ff <= req_error_bits;
      end
      if (do_capture) begin
         pend_slot_ff <= cur_head;
         pend_tag_ff  <= tag_rdata;
         pend_len_ff  <= (ring_ff == RING_RX) ? stat_rdata[LEN_W-1:0] : '0;
         pend_err_ff  <= (ring_ff == RING_RX) && stat_rdata[ERR_BIT];
      end
   end

endmodule

>>> test/descriptor_ring_tracker_top_tb.sv
module descriptor_ring_tracker_top_tb;
   import dring_pkg::*;

   localparam int SLOTS  = RING_SLOTS_DEF;
   // Settling time after the last result before a register write: covers a
   // done item or an empty reap still in flight.
   localparam int SETTLE = 16;
   // Receiver hold-off, long enough to back the block up into its input.
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      mode_type          mode;
      logic              ring;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic [IDX_W-1:0]  slot;
      logic [LEN_W-1:0]  flen;
      logic [ERR_W-1:0]  ebits;
   } req_item_type;

   typedef struct {
      status_type        status;
      logic [IDX_W-1:0]  tail;
      logic [IDX_W-1:0]  slot;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
      logic              err;
      logic              last;
   } ring_result_type;

   // Mirror of both rings plus the queue of results still owed by the block.
   class ring_ledger;
      logic [SIZE_W-1:0] frame_limit;
      bit                head_ok [2];
      bit [IDX_W-1:0]    head_at [2];
      bit [IDX_W-1:0]    free_at [2];
      bit [TAG_W-1:0]    tag_mem [2*SLOTS];
      bit                done_mem [2*SLOTS];
      bit [LEN_W-1:0]    len_mem [2*SLOTS];
      bit                err_mem [2*SLOTS];
      ring_result_type   pending_results [$];
      int                errors;
      int                adds_answered;
      int                refusals;
      int                reaped;
      int                deepest_reap;

      function new();
         frame_limit = FRAME_LIMIT_RESET;
      endfunction

      function int occupancy(logic r);
         if (!head_ok[r])
            return 0;
         return (int'(free_at[r]) - int'(head_at[r]) + SLOTS) % SLOTS;
      endfunction

      function void push_answer(status_type st, int tail, int slot, logic [TAG_W-1:0] tag,
                                logic [LEN_W-1:0] len, logic err, logic last);
         ring_result_type res;
         res.status = st;
         res.tail   = tail[IDX_W-1:0];
         res.slot   = slot[IDX_W-1:0];
         res.tag    = tag;
         res.len    = len;
         res.err    = err;
         res.last   = last;
         pending_results.push_back(res);
      endfunction

      // Work out what one accepted item does to the rings and what it answers.
      function void apply_request(req_item_type it);
         int base;
         int slot;
         int nxt;
         int n;
         bit refused;
         base = it.ring ? SLOTS : 0;
         case (it.mode)
            MODE_ADD: begin
               slot = int'(free_at[it.ring]);
               nxt  = (slot + 1) % SLOTS;
               adds_answered++;
               // A full ring wins over a bad size.
               if (head_ok[it.ring] && (slot == head_at[it.ring] || nxt == head_at[it.ring])) begin
                  refusals++;
                  push_answer(ST_FULL, slot, 0, '0, '0, 1'b0, 1'b1);
               end else begin
                  refused = (it.ring == RING_TX) ? (it.size > frame_limit)
                                                 : (it.size < frame_limit);
                  if (refused) begin
                     refusals++;
                     push_answer(ST_BAD_SIZE, slot, 0, '0, '0, 1'b0, 1'b1);
                  end else begin
                     tag_mem[base+slot]  = it.tag;
                     done_mem[base+slot] = 1'b0;
                     free_at[it.ring]    = nxt[IDX_W-1:0];
                     if (!head_ok[it.ring]) begin
                        head_ok[it.ring] = 1'b1;
                        head_at[it.ring] = slot[IDX_W-1:0];
                     end
                     push_answer(ST_ADDED, nxt, 0, '0, '0, 1'b0, 1'b1);
                  end
               end
            end
            MODE_DONE: begin
               if (int'(it.slot) < SLOTS) begin
                  done_mem[base+it.slot] = 1'b1;
                  len_mem[base+it.slot]  = it.flen;
                  err_mem[base+it.slot]  = (it.ebits != '0);
               end
            end
            MODE_REAP: begin
               n = 0;
               while (n < SLOTS-1 && head_ok[it.ring] && done_mem[base+head_at[it.ring]]) begin
                  slot = int'(head_at[it.ring]);
                  if (it.ring == RING_RX)
                     push_answer(ST_COMPLETION, 0, slot, tag_mem[base+slot], len_mem[base+slot],
                                 err_mem[base+slot], 1'b0);
                  else
                     push_answer(ST_COMPLETION, 0, slot, tag_mem[base+slot], '0, 1'b0, 1'b0);
                  n++;
                  head_at[it.ring] = IDX_W'((slot + 1) % SLOTS);
                  if (head_at[it.ring] == free_at[it.ring])
                     head_ok[it.ring] = 1'b0;
               end
               if (n > 0)
                  pending_results[pending_results.size()-1].last = 1'b1;
               reaped += n;
               if (n > deepest_reap)
                  deepest_reap = n;
            end
            default: ;
         endcase
      endfunction

      function void check_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void match_result(ring_result_type got);
         ring_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual status %0d slot %0d tag %0h",
                     $time, got.status, got.slot, got.tag);
            return;
         end
         want = pending_results.pop_front();
         check_field("status",      TAG_W'(want.status), TAG_W'(got.status));
         check_field("tail_index",  TAG_W'(want.tail),   TAG_W'(got.tail));
         check_field("done_slot",   TAG_W'(want.slot),   TAG_W'(got.slot));
         check_field("done_tag",    want.tag,            got.tag);
         check_field("done_length", TAG_W'(want.len),    TAG_W'(got.len));
         check_field("done_error",  TAG_W'(want.err),    TAG_W'(got.err));
         check_field("last_flag",   TAG_W'(want.last),   TAG_W'(got.last));
      endfunction
   endclass

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode         = '0;
   logic                req_ring         = 1'b0;
   logic [TAG_W-1:0]    req_buffer_tag   = '0;
   logic [SIZE_W-1:0]   req_buffer_size  = '0;
   logic [IDX_W-1:0]    req_slot_index   = '0;
   logic [LEN_W-1:0]    req_frame_length = '0;
   logic [ERR_W-1:0]    req_error_bits   = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_tail_index;
   logic [IDX_W-1:0]    rsp_done_slot;
   logic [TAG_W-1:0]    rsp_done_tag;
   logic [LEN_W-1:0]    rsp_done_length;
   logic                rsp_done_error;
   logic                rsp_last_flag;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_frame_limit  = '0;

   ring_ledger ledger;
   bit  steady       = 1'b0;   // no idling on either side while set
   bit  hold_request = 1'b0;   // ask the receiver for one long hold-off
   int  items_sent   = 0;
   int  limits_used  = 1;

   descriptor_ring_tracker_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_ring         (req_ring),
      .req_buffer_tag   (req_buffer_tag),
      .req_buffer_size  (req_buffer_size),
      .req_slot_index   (req_slot_index),
      .req_frame_length (req_frame_length),
      .req_error_bits   (req_error_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_tail_index   (rsp_tail_index),
      .rsp_done_slot    (rsp_done_slot),
      .rsp_done_tag     (rsp_done_tag),
      .rsp_done_length  (rsp_done_length),
      .rsp_done_error   (rsp_done_error),
      .rsp_last_flag    (rsp_last_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_limit  (csr_frame_limit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random, except in steady stretches, and hold off for a
   // long run of cycles when asked, so that the block backs up into its input.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 28);
         end
      end
   end

   // Result monitor: sample mid-cycle, where valid and stall are settled for the
   // coming edge, and check every item that edge will take.
   initial begin
      ring_result_type got;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.tail   = rsp_tail_index;
            got.slot   = rsp_done_slot;
            got.tag    = rsp_done_tag;
            got.len    = rsp_done_length;
            got.err    = rsp_done_error;
            got.last   = rsp_last_flag;
            ledger.match_result(got);
         end
      end
   end

   // Watchdog: a hung block or a lost result ends the run here.
   initial begin
      #10000000;
      $display("Verification failed");
      $finish;
   end

   function automatic req_item_type mk(mode_type m, logic r, logic [TAG_W-1:0] tag,
                                       logic [SIZE_W-1:0] size, logic [IDX_W-1:0] slot,
                                       logic [LEN_W-1:0] flen, logic [ERR_W-1:0] eb);
      req_item_type it;
      it.mode  = m;
      it.ring  = r;
      it.tag   = tag;
      it.size  = size;
      it.slot  = slot;
      it.flen  = flen;
      it.ebits = eb;
      return it;
   endfunction

   // Pick a buffer size against the current limit: mostly one that fits, some
   // that are refused, some right on the boundary.
   function automatic logic [SIZE_W-1:0] pick_size(logic r, bit fits_only);
      int lim;
      int p;
      lim = int'(ledger.frame_limit);
      p   = fits_only ? 99 : $urandom_range(0, 99);
      if (p < 15)
         return SIZE_W'(lim + $urandom_range(0, 2) - 1);
      if (p < 35) begin
         if (r == RING_TX && lim < 65535)
            return SIZE_W'($urandom_range(lim + 1, 65535));
         if (r == RING_RX && lim > 0)
            return SIZE_W'($urandom_range(0, lim - 1));
         return SIZE_W'($urandom);
      end
      return (r == RING_TX) ? SIZE_W'($urandom_range(0, lim))
                            : SIZE_W'($urandom_range(lim, 65535));
   endfunction

   // Random item with every field filled, then shaped by its mode. Done items
   // mostly land near the head of the ring so that reaps find work.
   function automatic req_item_type next_random_item();
      req_item_type it;
      int p;
      int occ;
      it = mk(MODE_ADD, 1'($urandom_range(0, 1)), $urandom, SIZE_W'($urandom),
              IDX_W'($urandom), LEN_W'($urandom), ERR_W'($urandom));
      p  = $urandom_range(0, 99);
      if (p < 45) begin
         it.mode = MODE_ADD;
         it.size = pick_size(it.ring, 1'b0);
      end else if (p < 75) begin
         it.mode = MODE_DONE;
         occ = ledger.occupancy(it.ring);
         if (occ > 0 && $urandom_range(0, 99) < 85)
            it.slot = IDX_W'((int'(ledger.head_at[it.ring]) +
                              $urandom_range(0, (occ > 8 ? 8 : occ) - 1)) % SLOTS);
         if ($urandom_range(0, 1))
            it.ebits = '0;
      end else if (p < 95) begin
         it.mode = MODE_REAP;
      end else begin
         it.mode = MODE_NONE;
      end
      return it;
   endfunction

   // Offer one item and hold it until taken. Valid is left high afterwards so
   // that the next item can follow back to back.
   task automatic send_item(input req_item_type it);
      bit taken;
      if (!steady && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_valid        <= 1'b1;
      req_mode         <= it.mode;
      req_ring         <= it.ring;
      req_buffer_tag   <= it.tag;
      req_buffer_size  <= it.size;
      req_slot_index   <= it.slot;
      req_frame_length <= it.flen;
      req_error_bits   <= it.ebits;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      ledger.apply_request(it);
      if (it.mode != MODE_NONE)
         items_sent++;
   endtask

   // Drop valid and wait until every owed result has arrived, then settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(input logic [SIZE_W-1:0] value);
      bit taken;
      csr_valid       <= 1'b1;
      csr_frame_limit <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      ledger.frame_limit = value;
      limits_used++;
   endtask

   task automatic run_random(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count)
         send_item(next_random_item());
   endtask

   // Fill one ring to capacity, knock on it while full, mark every slot done in
   // reverse order and reap the lot in one walk.
   task automatic fill_and_flush(input logic r);
      int guard;
      int occ;
      int slot;
      guard = 0;
      while (ledger.occupancy(r) < SLOTS-1 && guard < 2*SLOTS) begin
         send_item(mk(MODE_ADD, r, $urandom, pick_size(r, 1'b1), IDX_W'($urandom),
                      LEN_W'($urandom), ERR_W'($urandom)));
         guard++;
      end
      repeat (8)
         send_item(mk(MODE_ADD, r, $urandom, pick_size(r, 1'b0), IDX_W'($urandom),
                      LEN_W'($urandom), ERR_W'($urandom)));
      occ = ledger.occupancy(r);
      for (int off = occ - 1; off >= 0; off--) begin
         slot = (int'(ledger.head_at[r]) + off) % SLOTS;
         send_item(mk(MODE_DONE, r, $urandom, SIZE_W'($urandom), slot[IDX_W-1:0],
                      LEN_W'($urandom), ($urandom_range(0, 1) ? 8'h00 : 8'($urandom))));
      end
      send_item(mk(MODE_REAP, r, $urandom, SIZE_W'($urandom), IDX_W'($urandom),
                   LEN_W'($urandom), ERR_W'($urandom)));
   endtask

   initial begin
      logic [SIZE_W-1:0] mid_limit;
      ledger = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass at the reset limit of 1522.
      // Mark a slot with no buffer yet; the add that later lands there clears it.
      send_item(mk(MODE_DONE, RING_RX, '0, '0, 6'd2, 16'h1234, 8'h01));
      send_item(mk(MODE_ADD,  RING_RX, 32'hFFFF_FFFF, 16'd1522, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_RX, 32'h0, 16'd1521, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_RX, 32'h0, 16'd0, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_RX, 32'h0, 16'hFFFF, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_RX, 32'hA5A5_A5A5, 16'd1600, '0, '0, '0));
      // Head present but unfinished: nothing comes back.
      send_item(mk(MODE_REAP, RING_RX, '0, '0, '0, '0, '0));
      send_item(mk(MODE_DONE, RING_RX, '0, '0, 6'd0, 16'hFFFF, 8'hFF));
      send_item(mk(MODE_DONE, RING_RX, '0, '0, 6'd1, 16'h0000, 8'h00));
      // Two completions; the third slot had its early mark cleared by the add.
      send_item(mk(MODE_REAP, RING_RX, '0, '0, '0, '0, '0));
      // Empty transmit ring: nothing comes back.
      send_item(mk(MODE_REAP, RING_TX, '0, '0, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_TX, 32'h5A5A_5A5A, 16'd1522, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_TX, 32'h0, 16'd1523, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_TX, 32'h0, 16'hFFFF, '0, '0, '0));
      send_item(mk(MODE_ADD,  RING_TX, 32'h0, 16'd0, '0, '0, '0));
      send_item(mk(MODE_DONE, RING_TX, '0, '0, 6'd0, 16'hFFFF, 8'h80));
      send_item(mk(MODE_DONE, RING_TX, '0, '0, 6'd1, 16'h0001, 8'h00));
      // Unused mode with every bit set: ignored.
      send_item(mk(MODE_NONE, 1'b1, '1, '1, '1, '1, '1));
      // Transmit completions drop length and error.
      send_item(mk(MODE_REAP, RING_TX, '0, '0, '0, '0, '0));
      send_item(mk(MODE_DONE, RING_RX, '0, '0, 6'd2, 16'h8000, 8'h7F));
      send_item(mk(MODE_REAP, RING_RX, '0, '0, '0, '0, '0));
      send_item(mk(MODE_REAP, RING_RX, '0, '0, '0, '0, '0));
      send_item(mk(MODE_DONE, RING_RX, '0, '0, 6'd63, 16'h0000, 8'h00));
      drain();

      // Lowest limit: every receive size fits, only size zero may transmit.
      write_limit(16'd0);
      run_random(40);
      // Pause the sender until the block has answered everything.
      drain();
      run_random(40);
      drain();

      // Highest limit: every transmit size fits, only full-size receive buffers.
      write_limit(16'hFFFF);
      run_random(80);
      drain();

      // Mid limit so one ring, picked at random, sees refused sizes while full. Hold the
      // receiver off at the start so the answers back up into the input.
      mid_limit = SIZE_W'($urandom_range(1, 65534));
      write_limit(mid_limit);
      hold_request = 1'b1;
      fill_and_flush(1'($urandom_range(0, 1)));
      drain();

      // Back to the reset value, opening with a stretch free of idling.
      write_limit(FRAME_LIMIT_RESET);
      steady = 1'b1;
      run_random(40);
      steady = 1'b0;
      run_random(40);
      drain();

      $display("Sent %0d items over %0d frame limits: %0d add answers (%0d refused),",
               items_sent, limits_used, ledger.adds_answered, ledger.refusals);
      $display("%0d slots reaped, longest single reap %0d slots.",
               ledger.reaped, ledger.deepest_reap);
      if (ledger.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
src/dring_pkg.sv
src/dring_ram.sv
src/dring_ctrl.sv
src/descriptor_ring_tracker_top.sv
test/descriptor_ring_tracker_top_tb.sv
